// ===== hdl/dmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_pkg: shared types and constants of the dense matrix multiply unit
// Sizes of the element, product and accumulator words, the configuration
// register indexes and the size clamp that every size register goes through.
// ----------------------------------------------------------------------------
package dmm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int ELEM_BITS = 16;

	localparam int DIM_W   = $clog2(MAX_DIM + 1);        // holds 1..MAX_DIM
	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(2 * DEPTH);           // load position
	localparam int TOT_W   = $clog2(2 * DEPTH + 1);       // na + nb
	localparam int PROD_W  = 2 * ELEM_BITS;
	localparam int ACC_W   = 35;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ROWS_A    = 2'd0;
	localparam cfg_idx_t REG_INNER_LEN = 2'd1;
	localparam cfg_idx_t REG_COLS_B    = 2'd2;

	typedef logic signed [ELEM_BITS-1:0] elem_t;
	typedef logic signed [ACC_W-1:0]     acc_t;
	typedef logic [DIM_W-1:0]            dim_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [ADDR_W-1:0]           addr_t;

	// Clamp a size register: zero reads as one, anything above MAX_DIM saturates
	function automatic dim_t dim_sat(input logic [CFG_DATA_W-1:0] raw);
		dim_t res;
		if (raw == '0) begin
			res = DIM_W'(1);
		end else if (32'(raw) > MAX_DIM) begin
			res = DIM_W'(MAX_DIM);
		end else begin
			res = DIM_W'(raw);
		end
		return res;
	endfunction

endpackage

// ===== hdl/dmm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_in_if / dmm_out_if: valid/ready channels of the matrix multiply unit
// The input channel carries one matrix element a beat, the output channel
// one element of the result with its row, column and last mark.
// ----------------------------------------------------------------------------
interface dmm_in_if import dmm_pkg::*; ();
	logic  valid;
	logic  ready;
	elem_t element;

	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

interface dmm_out_if import dmm_pkg::*; ();
	logic  valid;
	logic  ready;
	acc_t  product_value;
	idx_t  out_row;
	idx_t  out_col;
	logic  last_element;

	modport source (output valid, output product_value, output out_row, output out_col,
		output last_element, input ready);
	modport sink   (input valid, input product_value, input out_row, input out_col,
		input last_element, output ready);
endinterface

// ===== hdl/dense_matrix_multiply_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply_unit: C = A x B over signed Q8.8 elements
// Loads A then B in row-major order into two element memories, then walks
// every result element with one shared multiplier and accumulator.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        element (16b signed Q8.8)
//  out_ch    out  valid/ready        product_value (35b Q19.16), out_row, out_col,
//                                    last_element
//  config    in   wr_en              wr_index (2b), wr_data (4b)
//
//  Loading takes one cycle per element beat; ready stays high throughout.
//  Each result element then passes through the multiply-add loop: the issue of
//  its inner_len products, one memory read and one multiply per cycle, then a
//  drain through the read registers and the product register, plus the output beat.
//  Reset clears the load position and sizes (8 x 8 x 8); no memory clearing.
//  A stalled output holds the loop; no input is taken until the last result goes.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_unit import dmm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dmm_in_if.sink                in_ch,
	dmm_out_if.source             out_ch,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]       state_q;
	dim_t             m_q, k_q, n_q;
	logic [CNT_W-1:0] load_cnt_q;
	idx_t             i_q, j_q, t_q;
	addr_t            a_base_q, a_addr_q, b_addr_q;

	elem_t            a_mem [DEPTH];
	elem_t            b_mem [DEPTH];
	elem_t            a_rd_s1, b_rd_s1;
	logic             vld_s1, last_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic             vld_s2, last_s2;
	acc_t             acc_q, acc_sum;

	logic             out_valid_q, out_last_q;
	acc_t             out_value_q;
	idx_t             out_row_q, out_col_q;

	logic [TOT_W-1:0] na, nb, total;
	logic [TOT_W-1:0] pos_next;
	logic             in_beat, out_beat, a_we, b_we;
	addr_t            b_waddr;
	idx_t             m_last, k_last, n_last;
	logic             iss_vld, iss_last;

	// Sizes and load split
	assign na       = TOT_W'(m_q * k_q);
	assign nb       = TOT_W'(k_q * n_q);
	assign total    = na + nb;
	assign pos_next = TOT_W'(load_cnt_q) + TOT_W'(1);
	assign m_last   = IDX_W'(m_q - DIM_W'(1));
	assign k_last   = IDX_W'(k_q - DIM_W'(1));
	assign n_last   = IDX_W'(n_q - DIM_W'(1));

	assign in_ch.ready = (state_q == ST_LOAD);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign out_beat    = out_valid_q && out_ch.ready;
	assign a_we        = in_beat && (TOT_W'(load_cnt_q) < na);
	assign b_we        = in_beat && !(TOT_W'(load_cnt_q) < na);
	assign b_waddr     = ADDR_W'(TOT_W'(load_cnt_q) - na);

	assign iss_vld  = (state_q == ST_MAC);
	assign iss_last = (t_q == k_last);
	assign acc_sum  = acc_q + ACC_W'(prod_s2);

	// Element memories: write on load beats, registered read for the loop
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[ADDR_W'(load_cnt_q)] <= in_ch.element;
		end
		if (b_we) begin
			b_mem[b_waddr] <= in_ch.element;
		end
		a_rd_s1 <= a_mem[a_addr_q];
		b_rd_s1 <= b_mem[b_addr_q];
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	// Pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= iss_vld;
			last_s1 <= iss_vld && iss_last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	// Sequencer: load, issue the multiply-adds, drain, hand out the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			m_q         <= DIM_W'(MAX_DIM);
			k_q         <= DIM_W'(MAX_DIM);
			n_q         <= DIM_W'(MAX_DIM);
			load_cnt_q  <= '0;
			i_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			a_base_q    <= '0;
			a_addr_q    <= '0;
			b_addr_q    <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Size writes restart the load
			if (wr_en) begin
				case (wr_index)
					REG_ROWS_A: begin
						m_q        <= dim_sat(wr_data);
						load_cnt_q <= '0;
					end
					REG_INNER_LEN: begin
						k_q        <= dim_sat(wr_data);
						load_cnt_q <= '0;
					end
					REG_COLS_B: begin
						n_q        <= dim_sat(wr_data);
						load_cnt_q <= '0;
					end
					default: ;
				endcase
			end

			// Accumulate products as they leave the multiplier
			if (vld_s2) begin
				acc_q <= acc_sum;
			end

			case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						if (pos_next == total) begin
							load_cnt_q <= '0;
							state_q    <= ST_MAC;
							i_q        <= '0;
							j_q        <= '0;
							t_q        <= '0;
							a_base_q   <= '0;
							a_addr_q   <= '0;
							b_addr_q   <= '0;
							acc_q      <= '0;
						end else begin
							load_cnt_q <= CNT_W'(pos_next);
						end
					end
				end
				ST_MAC: begin
					t_q      <= t_q + IDX_W'(1);
					a_addr_q <= a_addr_q + ADDR_W'(1);
					b_addr_q <= b_addr_q + ADDR_W'(n_q);
					if (iss_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (vld_s2 && last_s2) begin
						out_value_q <= acc_sum;
						out_row_q   <= i_q;
						out_col_q   <= j_q;
						out_last_q  <= (i_q == m_last) && (j_q == n_last);
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_beat) begin
						out_valid_q <= 1'b0;
						acc_q       <= '0;
						t_q         <= '0;
						if (out_last_q) begin
							state_q <= ST_LOAD;
						end else if (j_q == n_last) begin
							state_q  <= ST_MAC;
							i_q      <= i_q + IDX_W'(1);
							j_q      <= '0;
							a_base_q <= a_base_q + ADDR_W'(k_q);
							a_addr_q <= a_base_q + ADDR_W'(k_q);
							b_addr_q <= '0;
						end else begin
							state_q  <= ST_MAC;
							j_q      <= j_q + IDX_W'(1);
							a_addr_q <= a_base_q;
							b_addr_q <= ADDR_W'(j_q) + ADDR_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Drive the output channel
	assign out_ch.valid         = out_valid_q;
	assign out_ch.product_value = out_value_q;
	assign out_ch.out_row       = out_row_q;
	assign out_ch.out_col       = out_col_q;
	assign out_ch.last_element  = out_last_q;

	// Checks
	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input taken while a result is pending");

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (state_q == ST_OUT))
		else $error("result shown outside the output state");

	a_products_only_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (state_q == ST_MAC || state_q == ST_WAIT))
		else $error("product arrived outside the multiply loop");

	a_last_at_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.last_element) |->
		(out_ch.out_row == m_last && out_ch.out_col == n_last))
		else $error("last mark away from the final element");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (TOT_W'(load_cnt_q) < total))
		else $error("load position beyond the two matrices");

endmodule

// ===== tb/sv/tb_dense_matrix_multiply_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_matrix_multiply_unit: self-checking bench for the matrix multiply unit
// Streams A and B elements with random gaps, stalls the result channel at
// random, and checks every result element against a behavioural model of
// the multiply in the bench or a typed-in result. A short table of directed
// beats comes first, then largest, smallest and random shapes of random data.
// ----------------------------------------------------------------------------
module tb_dense_matrix_multiply_unit;
	import dmm_pkg::*;

	localparam int RANDOM_ITEMS   = 250;
	localparam int SETTLE_CYCLES  = 16;
	localparam int DRAIN_CYCLES   = 24;
	localparam int WATCHDOG_LIMIT = 2000;

	// index with no register behind it; a write there must be ignored
	localparam cfg_idx_t REG_NONE = 2'd3;

	typedef struct packed {
		acc_t value;
		idx_t row;
		idx_t col;
		logic last;
	} c_elem_t;

	typedef enum logic {ROW_WRITE, ROW_ELEM} row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		cfg_idx_t               idx;
		logic [CFG_DATA_W-1:0]  data;
		elem_t                  elem;
		logic                   hand_typed;
		acc_t                   value;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 21;

	// Directed beats: 1x1x1 extremes with results typed in, a load cut short by
	// a size write, saturated column count, and a write to the unused index.
	stim_row_t directed_plan [DIRECTED_ROWS] = '{
		'{ROW_WRITE, REG_ROWS_A,    4'd0,  16'sh0000, 1'b0, 35'sd0},
		'{ROW_WRITE, REG_INNER_LEN, 4'd0,  16'sh0000, 1'b0, 35'sd0},
		'{ROW_WRITE, REG_COLS_B,    4'd1,  16'sh0000, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh8000, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh8000, 1'b1, 35'sd1073741824},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh7FFF, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh8000, 1'b1, -35'sd1073709056},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh7FFF, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh7FFF, 1'b1, 35'sd1073676289},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh1234, 1'b0, 35'sd0},
		'{ROW_WRITE, REG_COLS_B,    4'd15, 16'sh0000, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'shFFFF, 1'b0, 35'sd0},
		'{ROW_WRITE, REG_NONE,      4'd0,  16'sh0000, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh0001, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'shFFFF, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh5555, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'shAAAA, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh7FFF, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh8000, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'sh0100, 1'b0, 35'sd0},
		'{ROW_ELEM,  REG_ROWS_A,    4'd0,  16'shFF00, 1'b0, 35'sd0}
	};

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	dmm_in_if  in_ch ();
	dmm_out_if out_ch ();

	dense_matrix_multiply_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Behavioural copy of the unit
	logic [CFG_DATA_W-1:0] rows_reg;
	logic [CFG_DATA_W-1:0] inner_reg;
	logic [CFG_DATA_W-1:0] cols_reg;
	elem_t                 a_mem [DEPTH];
	elem_t                 b_mem [DEPTH];
	int                    load_pos;
	c_elem_t               pending_c_q [$];

	// Hand-typed result travelling with the current beat
	logic    hand_typed;
	c_elem_t typed_c;

	int fail_count;
	int idle_cycles;
	int in_calm;
	int out_calm;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int size_of(input logic [CFG_DATA_W-1:0] code);
		if (code == '0) begin
			return 1;
		end
		if (int'(code) > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(code);
	endfunction

	// Draw a random gap, with occasional stretches of no gaps at all
	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_size_code();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 15));
			end
			2: begin
				return CFG_DATA_W'(MAX_DIM);
			end
			default: begin
				return CFG_DATA_W'($urandom_range(1, 4));
			end
		endcase
	endfunction

	function automatic elem_t rand_element();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(0, 7))
			0: begin
				return 16'sh7FFF;
			end
			1: begin
				return 16'sh8000;
			end
			2: begin
				return elem_t'($signed($urandom_range(0, 511)) - 256);
			end
			default: begin
				return elem_t'(raw[15:0]);
			end
		endcase
	endfunction

	// Apply a register write: any real register restarts the load
	task automatic apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ROWS_A: begin
				rows_reg = data;
				load_pos = 0;
			end
			REG_INNER_LEN: begin
				inner_reg = data;
				load_pos = 0;
			end
			REG_COLS_B: begin
				cols_reg = data;
				load_pos = 0;
			end
			default: begin
			end
		endcase
	endtask

	// Store one element; on the last element of B, queue every element of C
	task automatic load_and_multiply(input elem_t e);
		int      m, k, n, na, nb, i, j, t;
		longint  acc;
		c_elem_t r;
		m  = size_of(rows_reg);
		k  = size_of(inner_reg);
		n  = size_of(cols_reg);
		na = m * k;
		nb = k * n;
		if (load_pos < na) begin
			a_mem[load_pos] = e;
		end else begin
			b_mem[load_pos - na] = e;
		end
		load_pos++;
		if (load_pos < na + nb) begin
			return;
		end
		load_pos = 0;
		for (i = 0; i < m; i++) begin
			for (j = 0; j < n; j++) begin
				acc = 0;
				for (t = 0; t < k; t++) begin
					acc += longint'(a_mem[i * k + t]) * longint'(b_mem[t * n + j]);
				end
				r.value = acc_t'(acc);
				r.row   = idx_t'(i);
				r.col   = idx_t'(j);
				r.last  = (i == m - 1) && (j == n - 1);
				pending_c_q.push_back(r);
			end
		end
	endtask

	task automatic check_c_elem();
		c_elem_t want;
		if (pending_c_q.size() == 0) begin
			$error("result with none expected: row %0d col %0d value %0d",
				out_ch.out_row, out_ch.out_col, out_ch.product_value);
			fail_count++;
			return;
		end
		want = pending_c_q.pop_front();
		if (out_ch.product_value !== want.value) begin
			$error("product_value: expected %0d, got %0d", want.value, out_ch.product_value);
			fail_count++;
		end
		if (out_ch.out_row !== want.row) begin
			$error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
			fail_count++;
		end
		if (out_ch.out_col !== want.col) begin
			$error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
			fail_count++;
		end
		if (out_ch.last_element !== want.last) begin
			$error("last_element: expected %0d, got %0d", want.last, out_ch.last_element);
			fail_count++;
		end
	endtask

	// Sample every beat and write at the rising edge
	always @(posedge clk) begin
		int before_cnt;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				check_c_elem();
			end
			if (wr_en) begin
				apply_reg(wr_index, wr_data);
			end
			if (in_ch.valid && in_ch.ready) begin
				before_cnt = pending_c_q.size();
				load_and_multiply(in_ch.element);
				if (hand_typed) begin
					while (pending_c_q.size() > before_cnt) begin
						void'(pending_c_q.pop_back());
					end
					pending_c_q.push_back(typed_c);
				end
			end
			if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) || wr_en) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	// End the run if nothing moves for too long
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("** dense_matrix_multiply_unit: FAILED **");
		$finish;
	end

	// Result side: stall for a random number of cycles before each beat
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap(out_calm);
			if (gap > 0) begin
				out_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			@(negedge clk);
		end
	end

	// Present one element after a random gap; valid stays high afterwards
	task automatic push_element(input elem_t e, input logic typed, input acc_t value);
		int gap;
		gap = draw_gap(in_calm);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   = 1'b1;
		in_ch.element = e;
		hand_typed    = typed;
		typed_c.value = value;
		typed_c.row   = '0;
		typed_c.col   = '0;
		typed_c.last  = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid, wait for all results, then let the unit finish its last beat
	task automatic settle();
		in_ch.valid = 1'b0;
		hand_typed  = 1'b0;
		while (pending_c_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = data;
		@(posedge clk);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	initial begin
		int   row, phase, elems_sent, count;
		logic broken;
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = '0;
		wr_data       = '0;
		in_ch.valid   = 1'b0;
		in_ch.element = '0;
		hand_typed    = 1'b0;
		typed_c       = '0;
		fail_count    = 0;
		idle_cycles   = 0;
		in_calm       = 0;
		out_calm      = 0;
		rows_reg      = CFG_DATA_W'(MAX_DIM);
		inner_reg     = CFG_DATA_W'(MAX_DIM);
		cols_reg      = CFG_DATA_W'(MAX_DIM);
		load_pos      = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed_plan[row].kind == ROW_WRITE) begin
				write_reg(directed_plan[row].idx, directed_plan[row].data);
			end else begin
				push_element(directed_plan[row].elem, directed_plan[row].hand_typed,
					directed_plan[row].value);
			end
		end

		// Largest shape, then smallest, then random shapes and random contents
		elems_sent = 0;
		broken     = 1'b0;
		for (phase = 0; elems_sent < RANDOM_ITEMS; phase++) begin
			if (phase == 0) begin
				write_reg(REG_ROWS_A, 4'd15);
				write_reg(REG_INNER_LEN, CFG_DATA_W'(MAX_DIM));
				write_reg(REG_COLS_B, CFG_DATA_W'(MAX_DIM));
			end else if (phase == 1) begin
				write_reg(REG_ROWS_A, 4'd1);
				write_reg(REG_INNER_LEN, 4'd1);
				write_reg(REG_COLS_B, 4'd0);
			end else if (broken || $urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 15)));
				end
				write_reg(REG_ROWS_A, pick_size_code());
				write_reg(REG_INNER_LEN, pick_size_code());
				write_reg(REG_COLS_B, pick_size_code());
			end else if ($urandom_range(0, 2) == 0) begin
				write_reg(cfg_idx_t'($urandom_range(0, 2)), pick_size_code());
			end
			count = size_of(inner_reg) * (size_of(rows_reg) + size_of(cols_reg));
			broken = 1'b0;
			// Cut the odd load short; the next phase restarts it
			if (phase > 1 && count > 1 && $urandom_range(0, 7) == 0) begin
				count  = $urandom_range(1, count - 1);
				broken = 1'b1;
			end
			repeat (count) push_element(rand_element(), 1'b0, '0);
			elems_sent += count;
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_c_q.size() != 0) begin
			$error("%0d result elements never arrived", pending_c_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("** dense_matrix_multiply_unit: PASSED **");
		end else begin
			$display("** dense_matrix_multiply_unit: FAILED **");
		end
		$finish;
	end

endmodule
